// File: hdl/scvc_pkg.sv
// ============================================================================
// Sphere/cone visibility cull package
// Shared payload types, register indexes and reset values.
// ============================================================================
`default_nettype none

package scvc_pkg;

  // Fixed field widths
  localparam int COORD_BITS = 24;
  localparam int UNIT_BITS  = 16;
  localparam int RAD_BITS   = 24;
  localparam int CFG_DW     = 32;
  localparam int CFG_IW     = 3;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_CAM_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_CAM_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_CAM_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_FWD_X = 3'd3;
  localparam logic [CFG_IW-1:0] REG_FWD_Y = 3'd4;
  localparam logic [CFG_IW-1:0] REG_FWD_Z = 3'd5;
  localparam logic [CFG_IW-1:0] REG_CONE  = 3'd6;
  localparam logic [CFG_IW-1:0] REG_NEAR  = 3'd7;

  // Reset values
  localparam logic [UNIT_BITS-1:0] FWD_Z_RST = 16'd16384;
  localparam logic [CFG_DW-1:0]    CONE_RST  = 32'd389102503;
  localparam logic [RAD_BITS-1:0]  NEAR_RST  = 24'd25600;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] object_x;
    logic signed [COORD_BITS-1:0] object_y;
    logic signed [COORD_BITS-1:0] object_z;
    logic [RAD_BITS-1:0]          bound_radius;
    logic                         slot_empty;
  } scvc_in_t;

  typedef struct packed {
    logic visible;
    logic inside_cone;
    logic inside_near;
  } scvc_out_t;

endpackage

`default_nettype wire

// File: hdl/sphere_cone_visibility_cull.sv
// ============================================================================
// Sphere/cone visibility cull
// Streaming bounding-sphere versus view-cone and near-distance test.
// ============================================================================
// One object is accepted per clock and one result leaves per clock while the
// output is not stalled. The pipeline depth is set by the square-root pipeline,
// which resolves one root bit per stage. A stall on the output freezes the
// whole pipeline, so nothing is lost or repeated.
// Configuration registers are written through a plain write port and must only
// change while the pipeline is empty.
`default_nettype none

module sphere_cone_visibility_cull
  import scvc_pkg::*;
#(
  parameter int UNIT_FRAC_BITS = 14
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire scvc_in_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output scvc_out_t              out_data_o
);

  localparam int C    = COORD_BITS;
  localparam int U    = UNIT_FRAC_BITS;
  localparam int VW   = C + 1;
  localparam int SQW  = 2 * VW;
  localparam int LW   = SQW + 2;
  localparam int LSW  = (LW > 64) ? 64 : LW;
  localparam int RW   = LSW / 2;
  localparam int PDW  = VW + UNIT_BITS;
  localparam int P22W = PDW + 2;
  localparam int P8W  = P22W + 1 - U;
  localparam int MW   = (P8W > 32) ? 32 : P8W;
  localparam int CPW  = UNIT_BITS + RW + 1;
  localparam int SPW  = UNIT_BITS + P8W + 1;
  localparam int DW   = ((CPW > SPW) ? CPW : SPW) + 1;

  typedef struct packed {
    logic signed [P8W:0] p8;
    logic [RAD_BITS-1:0] radius;
    logic                near;
    logic                empty;
  } side_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [C-1:0]         cam_q [3];
  logic [UNIT_BITS-1:0] fwd_q [3];
  logic [CFG_DW-1:0]    cone_q;
  logic [RAD_BITS-1:0]  near_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q[0] <= '0;
      cam_q[1] <= '0;
      cam_q[2] <= '0;
      fwd_q[0] <= '0;
      fwd_q[1] <= '0;
      fwd_q[2] <= FWD_Z_RST;
      cone_q   <= CONE_RST;
      near_q   <= NEAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAM_X: cam_q[0] <= cfg_wdata_i[C-1:0];
        REG_CAM_Y: cam_q[1] <= cfg_wdata_i[C-1:0];
        REG_CAM_Z: cam_q[2] <= cfg_wdata_i[C-1:0];
        REG_FWD_X: fwd_q[0] <= cfg_wdata_i[UNIT_BITS-1:0];
        REG_FWD_Y: fwd_q[1] <= cfg_wdata_i[UNIT_BITS-1:0];
        REG_FWD_Z: fwd_q[2] <= cfg_wdata_i[UNIT_BITS-1:0];
        REG_CONE:  cone_q   <= cfg_wdata_i;
        REG_NEAR:  near_q   <= cfg_wdata_i[RAD_BITS-1:0];
        default:   ;
      endcase
    end
  end

  // Squared near distance, held static while items flow
  logic [2*RAD_BITS-1:0] nsq_q;
  always_ff @(posedge clk_i) begin
    nsq_q <= near_q * near_q;
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves when the output slot is free or taken
  // --------------------------------------------------------------------------
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, vp_q;
  logic sv_q [RW+1];

  // Stage 1: offset from camera
  logic signed [VW-1:0] off_q [3];
  logic [RAD_BITS-1:0]  rad1_q;
  logic                 emp1_q;
  logic signed [C-1:0]  obj [3];

  assign obj[0] = in_data_i.object_x;
  assign obj[1] = in_data_i.object_y;
  assign obj[2] = in_data_i.object_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        off_q[i] <= VW'(obj[i]) - VW'($signed(cam_q[i]));
      end
      rad1_q <= in_data_i.bound_radius;
      emp1_q <= in_data_i.slot_empty;
    end
  end

  // Stage 2: squares and forward products
  logic [SQW-1:0]        sq_q [3];
  logic signed [PDW-1:0] prd_q [3];
  logic [RAD_BITS-1:0]   rad2_q;
  logic                  emp2_q;
  logic [VW-1:0]         mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = off_q[i][VW-1] ? VW'(-off_q[i]) : VW'(off_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i]  <= mag[i] * mag[i];
        prd_q[i] <= PDW'(off_q[i] * $signed(fwd_q[i]));
      end
      rad2_q <= rad1_q;
      emp2_q <= emp1_q;
    end
  end

  // Stage 3: squared length (saturating) and projection sum
  logic [LSW-1:0]         len3_q;
  logic signed [P22W-1:0] p22_q;
  logic [RAD_BITS-1:0]    rad3_q;
  logic                   emp3_q;
  logic [LW-1:0]          lsum;

  assign lsum = LW'(sq_q[0]) + LW'(sq_q[1]) + LW'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      len3_q <= ((lsum >> LSW) != '0) ? '1 : lsum[LSW-1:0];
      p22_q  <= P22W'(prd_q[0]) + P22W'(prd_q[1]) + P22W'(prd_q[2]);
      rad3_q <= rad2_q;
      emp3_q <= emp2_q;
    end
  end

  // Stage 4: round projection to Q.8, half away from zero
  logic [P8W-1:0]      p8m_q;
  logic                pneg_q;
  logic [LSW-1:0]      len4_q;
  logic [RAD_BITS-1:0] rad4_q;
  logic                emp4_q;
  logic [P22W:0]       pmag;

  assign pmag = p22_q[P22W-1] ? (P22W+1)'(-p22_q) : (P22W+1)'(p22_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p8m_q  <= P8W'((pmag + (P22W+1)'(1 << (U - 1))) >> U);
      pneg_q <= p22_q[P22W-1];
      len4_q <= len3_q;
      rad4_q <= rad3_q;
      emp4_q <= emp3_q;
    end
  end

  // Stage 5: projection square and near test
  logic [63:0]    p8sq_q;
  logic [LSW-1:0] len5_q;
  side_t          sd5_q;
  logic [MW-1:0]  mlo;

  assign mlo = p8m_q[MW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p8sq_q       <= ((p8m_q >> 32) != '0) ? '1 : 64'(mlo * mlo);
      len5_q       <= len4_q;
      sd5_q.p8     <= pneg_q ? -$signed({1'b0, p8m_q}) : $signed({1'b0, p8m_q});
      sd5_q.radius <= rad4_q;
      sd5_q.near   <= 64'(len4_q) < 64'(nsq_q);
      sd5_q.empty  <= emp4_q;
    end
  end

  // Stage 6: perpendicular square, clamped at zero
  logic [LSW-1:0] x_q  [RW+1];
  logic [RW-1:0]  rt_q [RW+1];
  logic [RW+1:0]  rm_q [RW+1];
  side_t          sb_q [RW+1];
  logic [63:0]    pdiff;

  assign pdiff = 64'(len5_q) - p8sq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0]  <= (64'(len5_q) > p8sq_q) ? pdiff[LSW-1:0] : '0;
      rt_q[0] <= '0;
      rm_q[0] <= '0;
      sb_q[0] <= sd5_q;
    end
  end

  // Square-root stages: resolve one root bit per stage, MSB first
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int I = RW - 1 - k;
    logic [RW+1:0] rsh;
    logic [RW+1:0] trial;
    logic          ge;

    assign rsh   = {rm_q[k][RW-1:0], x_q[k][2*I+1 -: 2]};
    assign trial = {rt_q[k], 2'b01};
    assign ge    = rsh >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        x_q[k+1]  <= x_q[k];
        rt_q[k+1] <= {rt_q[k][RW-2:0], ge};
        rm_q[k+1] <= ge ? rsh - trial : rsh;
        sb_q[k+1] <= sb_q[k];
      end
    end
  end

  // Product stage: cos * perp and sin * p
  logic signed [CPW-1:0] cp_q;
  logic signed [SPW-1:0] sp_q;
  side_t                 sbp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_q  <= CPW'($signed(cone_q[31:16]) * $signed({1'b0, rt_q[RW]}));
      sp_q  <= SPW'($signed(cone_q[15:0]) * sb_q[RW].p8);
      sbp_q <= sb_q[RW];
    end
  end

  // Output stage: compare cone distance with radius
  logic signed [DW-1:0] cone_dist;
  logic signed [DW-1:0] rad22;
  logic                 cone;

  assign cone_dist = DW'(cp_q) - DW'(sp_q);
  assign rad22     = $signed(DW'({sbp_q.radius, U'(0)}));
  assign cone      = cone_dist < rad22;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.inside_cone <= cone && !sbp_q.empty;
      out_data_o.inside_near <= sbp_q.near && !sbp_q.empty;
      out_data_o.visible     <= (cone || sbp_q.near) && !sbp_q.empty;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      vp_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      vp_q        <= sv_q[RW];
      out_valid_o <= vp_q;
    end
  end

  assign sv_q[0] = v6_q;
  for (genvar k = 0; k < RW; k++) begin : g_sv
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (en) begin
        sv_q[k+1] <= sv_q[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/scvc_checker.sv
// ============================================================================
// Sphere/cone visibility cull checker
// Port-level checks on the handshakes and the result stream, bound to the top level.
// ============================================================================
`default_nettype none

module scvc_checker
  import scvc_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire scvc_out_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Visible is the OR of the two tests
  a_vis_or: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.visible ==
      (out_data_o.inside_cone || out_data_o.inside_near))
    else $error("visible flag inconsistent");

  // Drop ready only on an output stall
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // Advance on every output transfer
  a_xfer_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("pipeline held during output transfer");

endmodule

bind sphere_cone_visibility_cull scvc_checker u_scvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
